>>> sv/nlfr_pkg.sv
// ----------------------------------------------------------------------------
// nlfr_pkg
// shared types and constants for the nibble link frame receiver
// ----------------------------------------------------------------------------
package nlfr_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_STREAM  = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_TIMEOUT = 2'd3
    } kind_t;

    // input function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_ARM    = 1'b1;

    // control codes carried on the nibble lines
    localparam logic [3:0] FRAME_OPEN  = 4'h1;
    localparam logic [3:0] FRAME_CLOSE = 4'h2;

    // opcode that switches the frame to stream mode
    localparam logic [7:0] STREAM_OPCODE = 8'h03;

    // configuration register indexes
    localparam logic REG_PAYLOAD_LIMIT = 1'b0;
    localparam logic REG_TIMEOUT_POLLS = 1'b1;

    localparam int CFG_DATA_W  = 20;
    localparam int LIMIT_W     = 10;
    localparam int POLLS_W     = 20;

    localparam logic [LIMIT_W-1:0] PAYLOAD_LIMIT_RST = 10'd512;
    localparam logic [POLLS_W-1:0] TIMEOUT_POLLS_RST = 20'd500000;

    // one result word
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [8:0]  byte_index;
        logic [7:0]  frame_opcode;
        logic [9:0]  frame_length;
    } result_t;

endpackage

>>> sv/nibble_link_frame_receiver.sv
// ----------------------------------------------------------------------------
// nibble_link_frame_receiver
// frame receiver for a 6-line half-duplex nibble link
// ----------------------------------------------------------------------------
// throughput: one sample word per cycle while the result slot is free; input
//   register feeds one pass of decode logic into the result register
// reset: rst_n clears the link state and control; payload_limit resets to 512,
//   timeout_polls to 500000; the receiver comes out of reset disarmed
// ----------------------------------------------------------------------------
module nibble_link_frame_receiver
    import nlfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 512
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // sample channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [5:0]            port_sample,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            kind,
    output logic [7:0]            data_byte,
    output logic [8:0]            byte_index,
    output logic [7:0]            frame_opcode,
    output logic [9:0]            frame_length
);

    // kept length can never pass the buffer size nor the limit register range
    localparam int LimitMax = (1 << LIMIT_W) - 1;
    localparam int CapVal   = (MAX_PAYLOAD > LimitMax) ? LimitMax : MAX_PAYLOAD;
    localparam logic [LIMIT_W-1:0] LimitCap = LIMIT_W'(CapVal);

    // configuration registers
    logic [LIMIT_W-1:0] payload_limit_reg;
    logic [POLLS_W-1:0] timeout_polls_reg;
    logic [LIMIT_W-1:0] limit_eff;

    // input register
    logic       in_full_reg;
    logic       func_reg;
    logic [5:0] sample_reg;

    // pass control
    logic    step;
    logic    slot_free;
    logic    res_valid;
    result_t res;
    result_t out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_limit_reg <= PAYLOAD_LIMIT_RST;
            timeout_polls_reg <= TIMEOUT_POLLS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PAYLOAD_LIMIT: payload_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_TIMEOUT_POLLS: payload_limit_reg <= payload_limit_reg;
                default:           payload_limit_reg <= payload_limit_reg;
            endcase
            if (cfg_index == REG_TIMEOUT_POLLS)
            begin
                timeout_polls_reg <= cfg_data[POLLS_W-1:0];
            end
        end
    end

    assign limit_eff = (payload_limit_reg > LimitCap) ? LimitCap : payload_limit_reg;

    // the held word is decoded once the result slot can take its outcome
    assign step     = in_full_reg && slot_free;
    // a new word may enter whenever the held one moves on this cycle
    assign in_stall = in_full_reg && !slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            func_reg   <= func;
            sample_reg <= port_sample;
        end
    end

    // link state and frame decode
    nlfr_frame u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .func          (func_reg),
        .port_sample   (sample_reg),
        .limit         (limit_eff),
        .timeout_polls (timeout_polls_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    // result register
    nlfr_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res       (res),
        .out_stall (out_stall),
        .free      (slot_free),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign data_byte    = out_res.data_byte;
    assign byte_index   = out_res.byte_index;
    assign frame_opcode = out_res.frame_opcode;
    assign frame_length = out_res.frame_length;

endmodule

>>> sv/nlfr_frame.sv
// ----------------------------------------------------------------------------
// nlfr_frame
// link state and frame decode, one sample per cycle while step is asserted
// ----------------------------------------------------------------------------
module nlfr_frame
    import nlfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 func,
    input  logic [5:0]           port_sample,
    input  logic [LIMIT_W-1:0]   limit,
    input  logic [POLLS_W-1:0]   timeout_polls,
    output logic                 res_valid,
    output result_t              res
);

    logic                armed_reg,       armed_next;
    logic                last_clock_reg,  last_clock_next;
    logic                in_frame_reg,    in_frame_next;
    logic                have_high_reg,   have_high_next;
    logic [3:0]          high_nibble_reg, high_nibble_next;
    logic                got_opcode_reg,  got_opcode_next;
    logic [7:0]          opcode_reg,      opcode_next;
    logic [LIMIT_W-1:0]  byte_count_reg,  byte_count_next;
    logic [POLLS_W-1:0]  countdown_reg,   countdown_next;
    logic                stream_reg,      stream_next;

    logic       clk_bit;
    logic       ctrl_bit;
    logic [3:0] nib;
    logic [7:0] assembled;

    assign clk_bit   = port_sample[5];
    assign ctrl_bit  = port_sample[4];
    assign nib       = port_sample[3:0];
    assign assembled = {high_nibble_reg, nib};

    always_comb
    begin
        armed_next       = armed_reg;
        last_clock_next  = last_clock_reg;
        in_frame_next    = in_frame_reg;
        have_high_next   = have_high_reg;
        high_nibble_next = high_nibble_reg;
        got_opcode_next  = got_opcode_reg;
        opcode_next      = opcode_reg;
        byte_count_next  = byte_count_reg;
        countdown_next   = countdown_reg;
        stream_next      = stream_reg;
        res_valid        = 1'b0;
        res              = '0;

        if (step)
        begin
            if (func == FUNC_ARM)
            begin
                armed_next       = 1'b1;
                last_clock_next  = clk_bit;
                countdown_next   = timeout_polls;
                in_frame_next    = 1'b0;
                have_high_next   = 1'b0;
                high_nibble_next = '0;
                got_opcode_next  = 1'b0;
                opcode_next      = '0;
                byte_count_next  = '0;
                stream_next      = 1'b0;
            end
            else if (armed_reg)
            begin
                if (clk_bit == last_clock_reg)
                begin
                    // no link edge: outside stream mode, count down toward timeout
                    if (!stream_reg)
                    begin
                        if (countdown_reg <= POLLS_W'(1))
                        begin
                            countdown_next   = '0;
                            armed_next       = 1'b0;
                            in_frame_next    = 1'b0;
                            have_high_next   = 1'b0;
                            high_nibble_next = '0;
                            got_opcode_next  = 1'b0;
                            opcode_next      = '0;
                            byte_count_next  = '0;
                            stream_next      = 1'b0;
                            res_valid        = 1'b1;
                            res.kind         = KIND_TIMEOUT;
                        end
                        else
                        begin
                            countdown_next = countdown_reg - POLLS_W'(1);
                        end
                    end
                end
                else
                begin
                    last_clock_next = clk_bit;
                    if (stream_reg)
                    begin
                        if (ctrl_bit)
                        begin
                            if (nib == FRAME_CLOSE)
                            begin
                                armed_next       = 1'b0;
                                in_frame_next    = 1'b0;
                                have_high_next   = 1'b0;
                                high_nibble_next = '0;
                                got_opcode_next  = 1'b0;
                                opcode_next      = '0;
                                byte_count_next  = '0;
                                stream_next      = 1'b0;
                                res_valid        = 1'b1;
                                res.kind         = KIND_DONE;
                                res.frame_opcode = STREAM_OPCODE;
                            end
                        end
                        else if (!have_high_reg)
                        begin
                            high_nibble_next = nib;
                            have_high_next   = 1'b1;
                        end
                        else
                        begin
                            have_high_next = 1'b0;
                            res_valid      = 1'b1;
                            res.kind       = KIND_STREAM;
                            res.data_byte  = assembled;
                        end
                    end
                    else
                    begin
                        countdown_next = timeout_polls;
                        if (ctrl_bit)
                        begin
                            if (nib == FRAME_OPEN)
                            begin
                                in_frame_next   = 1'b1;
                                have_high_next  = 1'b0;
                                got_opcode_next = 1'b0;
                                byte_count_next = '0;
                            end
                            else if (nib == FRAME_CLOSE && in_frame_reg)
                            begin
                                armed_next       = 1'b0;
                                in_frame_next    = 1'b0;
                                have_high_next   = 1'b0;
                                high_nibble_next = '0;
                                got_opcode_next  = 1'b0;
                                opcode_next      = '0;
                                byte_count_next  = '0;
                                stream_next      = 1'b0;
                                res_valid        = 1'b1;
                                res.kind         = KIND_DONE;
                                res.frame_opcode = opcode_reg;
                                res.frame_length = byte_count_reg;
                            end
                        end
                        else if (in_frame_reg)
                        begin
                            if (!have_high_reg)
                            begin
                                high_nibble_next = nib;
                                have_high_next   = 1'b1;
                            end
                            else
                            begin
                                have_high_next = 1'b0;
                                if (!got_opcode_reg)
                                begin
                                    opcode_next     = assembled;
                                    got_opcode_next = 1'b1;
                                    if (assembled == STREAM_OPCODE)
                                    begin
                                        stream_next = 1'b1;
                                    end
                                end
                                else if (byte_count_reg < limit)
                                begin
                                    byte_count_next = byte_count_reg + LIMIT_W'(1);
                                    res_valid       = 1'b1;
                                    res.kind        = KIND_PAYLOAD;
                                    res.data_byte   = assembled;
                                    res.byte_index  = byte_count_reg[8:0];
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg       <= 1'b0;
            last_clock_reg  <= 1'b1;
            in_frame_reg    <= 1'b0;
            have_high_reg   <= 1'b0;
            high_nibble_reg <= '0;
            got_opcode_reg  <= 1'b0;
            opcode_reg      <= '0;
            byte_count_reg  <= '0;
            countdown_reg   <= '0;
            stream_reg      <= 1'b0;
        end
        else
        begin
            armed_reg       <= armed_next;
            last_clock_reg  <= last_clock_next;
            in_frame_reg    <= in_frame_next;
            have_high_reg   <= have_high_next;
            high_nibble_reg <= high_nibble_next;
            got_opcode_reg  <= got_opcode_next;
            opcode_reg      <= opcode_next;
            byte_count_reg  <= byte_count_next;
            countdown_reg   <= countdown_next;
            stream_reg      <= stream_next;
        end
    end

endmodule

>>> sv/nlfr_out_reg.sv
// ----------------------------------------------------------------------------
// nlfr_out_reg
// result register toward the output channel
// ----------------------------------------------------------------------------
module nlfr_out_reg
    import nlfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_stall,
    output logic    free,
    output logic    out_valid,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // slot can take a word when empty or when the held word leaves this cycle
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule
